@@ design/fbs_pkg.sv @@
// Shared types and constants of the five-level feedback scheduler.
package fbs_pkg;

    localparam int ID_W       = 8;
    localparam int TIME_W     = 16;
    localparam int LEVEL_W    = 3;
    localparam int ENTRY_W    = ID_W + TIME_W;
    localparam int NUM_QUANTA = 4;
    localparam int QIDX_W     = $clog2(NUM_QUANTA);
    localparam int QSLOTS     = 2;
    localparam int DATA_W     = 32;
    localparam int CFG_AW     = 4;

    localparam logic REQ_ADMIT    = 1'b0;
    localparam logic REQ_DISPATCH = 1'b1;

    typedef enum logic [2:0] {
        STATUS_ADMITTED = 3'd0,
        STATUS_REJECTED = 3'd1,
        STATUS_FINISHED = 3'd2,
        STATUS_DEMOTED  = 3'd3,
        STATUS_IDLE     = 3'd4,
        STATUS_LOST     = 3'd5
    } status_t;

    typedef enum logic {
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    typedef struct packed {
        logic               req_type;
        logic [ID_W-1:0]    pid;
        logic [TIME_W-1:0]  burst;
        logic [LEVEL_W-1:0] level;
    } fbs_req_t;

    typedef logic [NUM_QUANTA-1:0][TIME_W-1:0] quanta_t;

endpackage

@@ design/fbs_front.sv @@
// Input stage: takes stream words, clamps the start level and hands requests on.
module fbs_front #(
    parameter int NUM_LEVELS = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fbs_pkg::DATA_W-1:0] s_tdata,  // process_id, burst_len, start_priority
    input  logic                       s_tuser,  // req_type
    output fbs_pkg::fbs_req_t          req,
    output logic                       req_valid,
    input  logic                       req_ready
);
    import fbs_pkg::*;

    fbs_req_t           req_reg;
    fbs_req_t           req_next;
    logic               valid_reg;
    logic [LEVEL_W-1:0] prio;

    assign s_tready  = !valid_reg || req_ready;
    assign req       = req_reg;
    assign req_valid = valid_reg;

    always_comb
    begin
        prio = s_tdata[26:24];
        req_next.req_type = s_tuser;
        req_next.pid      = s_tdata[7:0];
        req_next.burst    = s_tdata[23:8];
        // Start levels are numbered from one; out-of-range values are clamped.
        if (prio == '0)
        begin
            req_next.level = '0;
        end
        else if ({1'b0, prio} > (LEVEL_W + 1)'(NUM_LEVELS))
        begin
            req_next.level = LEVEL_W'(NUM_LEVELS - 1);
        end
        else
        begin
            req_next.level = prio - LEVEL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg <= req_next;
        end
    end

endmodule

@@ design/fbs_queue.sv @@
// Short request queue that decouples the input stage from the executing stage.
module fbs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  fbs_pkg::fbs_req_t wr_req,
    input  logic              wr_valid,
    output logic              wr_ready,
    output fbs_pkg::fbs_req_t rd_req,
    output logic              rd_valid,
    input  logic              rd_ready
);
    import fbs_pkg::*;

    localparam int IDX_W = $clog2(QSLOTS);
    localparam int CNT_W = $clog2(QSLOTS + 1);

    fbs_req_t         slot_reg [QSLOTS];
    logic [IDX_W-1:0] wr_ptr_reg;
    logic [IDX_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign wr_ready = (count_reg != CNT_W'(QSLOTS));
    assign rd_valid = (count_reg != '0);
    assign rd_req   = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == IDX_W'(QSLOTS - 1)) ? '0 : wr_ptr_reg + IDX_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == IDX_W'(QSLOTS - 1)) ? '0 : rd_ptr_reg + IDX_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_req;
        end
    end

endmodule

@@ design/fbs_back.sv @@
// Executing stage: level queues in memory, admit and dispatch, output register.
module fbs_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  fbs_pkg::fbs_req_t          req,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  fbs_pkg::quanta_t           quanta,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fbs_pkg::DATA_W-1:0] m_tdata,  // served_id, served_level, time_left
    output logic [2:0]                 m_tuser   // status
);
    import fbs_pkg::*;

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);

    back_state_t        state_reg;
    back_state_t        state_next;
    logic [PTR_W-1:0]   head_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]   head_next [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_reg  [NUM_LEVELS];
    logic [PTR_W-1:0]   tail_next [NUM_LEVELS];
    logic [CNT_W-1:0]   count_reg [NUM_LEVELS];
    logic [CNT_W-1:0]   count_next[NUM_LEVELS];
    logic [LEVEL_W-1:0] lvl_reg;
    logic [LEVEL_W-1:0] lvl_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    status_t            out_status_reg;
    status_t            out_status_next;
    logic [ID_W-1:0]    out_id_reg;
    logic [ID_W-1:0]    out_id_next;
    logic [LEVEL_W-1:0] out_level_reg;
    logic [LEVEL_W-1:0] out_level_next;
    logic [TIME_W-1:0]  out_time_reg;
    logic [TIME_W-1:0]  out_time_next;

    logic [ENTRY_W-1:0] mem [MEM_DEPTH];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               mem_we;
    logic [MEM_AW-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;

    logic               out_free;
    logic               found;
    logic [LEVEL_W-1:0] found_lvl;
    logic [QIDX_W-1:0]  qidx;
    logic [TIME_W-1:0]  rem;
    logic [TIME_W-1:0]  quantum;
    logic [LEVEL_W-1:0] next_lvl;

    function automatic logic [MEM_AW-1:0] entry_addr(input logic [LEVEL_W-1:0] lvl,
                                                     input logic [PTR_W-1:0] ptr);
        return MEM_AW'(int'(lvl) * QUEUE_DEPTH + int'(ptr));
    endfunction

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {(DATA_W - TIME_W - LEVEL_W - ID_W)'(0),
                       out_time_reg, out_level_reg, out_id_reg};

    // Highest-priority nonempty level; level zero wins.
    always_comb
    begin
        found     = 1'b0;
        found_lvl = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (count_reg[l] != '0)
            begin
                found     = 1'b1;
                found_lvl = LEVEL_W'(l);
            end
        end
    end

    always_comb
    begin
        qidx     = (lvl_reg >= LEVEL_W'(NUM_QUANTA)) ? QIDX_W'(NUM_QUANTA - 1)
                                                     : lvl_reg[QIDX_W-1:0];
        quantum  = quanta[qidx];
        rem      = rd_data_reg[TIME_W-1:0];
        next_lvl = lvl_reg + LEVEL_W'(1);
    end

    always_comb
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (req_valid && out_free && req.req_type == REQ_DISPATCH && found)
                begin
                    state_next = BK_EXEC;
                end
                else
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_EXEC:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        lvl_next        = lvl_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_level_next  = out_level_reg;
        out_time_next   = out_time_reg;
        req_ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        case (state_reg)
            BK_IDLE:
            begin
                req_ready = out_free;
                if (req_valid && out_free)
                begin
                    if (req.req_type == REQ_ADMIT)
                    begin
                        out_valid_next = 1'b1;
                        out_id_next    = req.pid;
                        out_level_next = req.level;
                        out_time_next  = req.burst;
                        if (count_reg[req.level] == CNT_W'(QUEUE_DEPTH))
                        begin
                            out_status_next = STATUS_REJECTED;
                        end
                        else
                        begin
                            out_status_next       = STATUS_ADMITTED;
                            mem_we                = 1'b1;
                            mem_waddr             = entry_addr(req.level, tail_reg[req.level]);
                            mem_wdata             = {req.pid, req.burst};
                            tail_next[req.level]  = ptr_inc(tail_reg[req.level]);
                            count_next[req.level] = count_reg[req.level] + CNT_W'(1);
                        end
                    end
                    else if (!found)
                    begin
                        out_valid_next  = 1'b1;
                        out_status_next = STATUS_IDLE;
                        out_id_next     = '0;
                        out_level_next  = '0;
                        out_time_next   = '0;
                    end
                    else
                    begin
                        // Pop the head now; the entry is evaluated in the next cycle.
                        rd_en                = 1'b1;
                        rd_addr              = entry_addr(found_lvl, head_reg[found_lvl]);
                        head_next[found_lvl] = ptr_inc(head_reg[found_lvl]);
                        count_next[found_lvl] = count_reg[found_lvl] - CNT_W'(1);
                        lvl_next             = found_lvl;
                    end
                end
            end
            BK_EXEC:
            begin
                out_valid_next = 1'b1;
                out_id_next    = rd_data_reg[ENTRY_W-1:TIME_W];
                out_level_next = lvl_reg;
                if (lvl_reg == LEVEL_W'(NUM_LEVELS - 1) || rem <= quantum)
                begin
                    out_status_next = STATUS_FINISHED;
                    out_time_next   = '0;
                end
                else
                begin
                    out_time_next = rem - quantum;
                    if (count_reg[next_lvl] == CNT_W'(QUEUE_DEPTH))
                    begin
                        out_status_next = STATUS_LOST;
                    end
                    else
                    begin
                        out_status_next      = STATUS_DEMOTED;
                        mem_we               = 1'b1;
                        mem_waddr            = entry_addr(next_lvl, tail_reg[next_lvl]);
                        mem_wdata            = {rd_data_reg[ENTRY_W-1:TIME_W], rem - quantum};
                        tail_next[next_lvl]  = ptr_inc(tail_reg[next_lvl]);
                        count_next[next_lvl] = count_reg[next_lvl] + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            out_valid_reg <= 1'b0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                head_reg[l]  <= '0;
                tail_reg[l]  <= '0;
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg        <= lvl_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_level_reg  <= out_level_next;
        out_time_reg   <= out_time_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

@@ design/five_level_feedback_scheduler_top.sv @@
// Top level of the five-level feedback scheduler with its quantum registers.
//
// Requests enter on the s_ stream: tuser selects admit or dispatch, tdata carries
// the process id, burst time and start level. Each request yields one result word
// on the m_ stream with its status in tuser and id, level and time left in tdata.
// Quanta of the first four levels are set through the APB port; a write of zero
// is stored as one, and deeper levels reuse the fourth quantum.
// An input register and a two-entry queue feed the executing stage, which keeps
// all level queues in one memory of NUM_LEVELS * QUEUE_DEPTH entries.
// An admit is finished in the idle state of the executing stage. A dispatch first
// reads the queue head from memory, then compares, subtracts and, on demotion,
// writes the entry back to the next level.
// After reset all levels are empty and every quantum is one; no clearing pass.
// When the receiver stalls, the result register holds its word, the queue fills
// and then s_tready drops; no word is lost.
module five_level_feedback_scheduler_top #(
    parameter int QUEUE_DEPTH = 16,
    parameter int NUM_LEVELS  = 5
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [fbs_pkg::DATA_W-1:0] s_tdata,  // process_id, burst_len, start_priority
    input  logic                       s_tuser,  // req_type
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [fbs_pkg::DATA_W-1:0] m_tdata,  // served_id, served_level, time_left
    output logic [2:0]                 m_tuser,  // status
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fbs_pkg::CFG_AW-1:0] paddr,
    input  logic [fbs_pkg::DATA_W-1:0] pwdata,
    output logic [fbs_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    import fbs_pkg::*;

    quanta_t           quantum_reg;
    logic              cfg_write;
    logic [QIDX_W-1:0] cfg_idx;
    logic [TIME_W-1:0] cfg_val;
    fbs_req_t          front_req;
    logic              front_valid;
    logic              front_ready;
    fbs_req_t          back_req;
    logic              back_valid;
    logic              back_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[CFG_AW-1:2];
    assign cfg_val   = pwdata[TIME_W-1:0];
    assign prdata    = DATA_W'(quantum_reg[cfg_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUANTA; i++)
            begin
                quantum_reg[i] <= TIME_W'(1);
            end
        end
        else if (cfg_write)
        begin
            quantum_reg[cfg_idx] <= (cfg_val == '0) ? TIME_W'(1) : cfg_val;
        end
    end

    fbs_front #(
        .NUM_LEVELS (NUM_LEVELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .req       (front_req),
        .req_valid (front_valid),
        .req_ready (front_ready)
    );

    fbs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_req   (front_req),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_req   (back_req),
        .rd_valid (back_valid),
        .rd_ready (back_ready)
    );

    fbs_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_LEVELS  (NUM_LEVELS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (back_req),
        .req_valid (back_valid),
        .req_ready (back_ready),
        .quanta    (quantum_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
